// File: rtl/core/rha_pkg.sv
// Shared types, constants and command/status structs of the radix handle allocator.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package rha_pkg;

	localparam int HANDLE_BITS  = 24;
	localparam int IDX_BITS     = 8;
	localparam int ENTRIES      = 256;
	localparam int CNT_BITS     = 9;
	localparam int USED_BITS    = 25;
	localparam int DEF_FRAMES   = 64;
	localparam int SCAN_CHUNK   = 32;
	localparam logic [USED_BITS-1:0] FULL_COUNT = 25'h1000000;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOMEM    = 2'd1,
		ST_NOTALLOC = 2'd2,
		ST_FULL     = 2'd3
	} rha_status_t;

	typedef struct packed {
		logic                   req_type;
		logic [HANDLE_BITS-1:0] handle_in;
	} rha_req_t;

	typedef struct packed {
		rha_status_t            status;
		logic [HANDLE_BITS-1:0] handle_out;
		logic [USED_BITS-1:0]   used_total;
	} rha_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DECODE,
		S_A_RDTOP, S_A_TOP, S_A_FIND_L2, S_A_L2E, S_A_FIND_LF, S_A_NEWLEAF, S_A_LFE,
		S_F_TOP, S_F_L2E, S_F_LFE, S_F_GIVE,
		S_OUT
	} rha_state_t;

	typedef enum logic {ERD_L2_TOP, ERD_LEAF_ENT} rha_ent_rsel_t;
	typedef enum logic {EWR_L2_SLOT, EWR_LEAF_SLOT} rha_ent_wsel_t;
	typedef enum logic [1:0] {EWD_FOUND, EWD_USED, EWD_EMPTY} rha_ent_wdat_t;
	typedef enum logic {CRD_TOP, CRD_ENT} rha_cnt_rsel_t;
	typedef enum logic [1:0] {CWR_FOUND, CWR_L2, CWR_LEAF} rha_cnt_wsel_t;
	typedef enum logic [2:0] {
		CWD_ONE, CWD_L2_INC, CWD_LEAF_INC, CWD_LEAF_DEC, CWD_L2_DEC
	} rha_cnt_wdat_t;
	typedef enum logic [1:0] {L2_HOLD, L2_FROM_TOP, L2_FROM_FOUND} rha_l2_ld_t;
	typedef enum logic [1:0] {LF_HOLD, LF_FROM_ENT, LF_FROM_FOUND} rha_leaf_ld_t;
	typedef enum logic [1:0] {
		POOL_NONE, POOL_TAKE, POOL_GIVE_L2, POOL_GIVE_LEAF
	} rha_pool_op_t;

	typedef struct packed {
		logic          clear;
		logic          accept;
		logic          load_alloc;
		logic          top_rd;
		logic          top_wr;
		logic          top_wr_empty;
		logic          ent_rd;
		rha_ent_rsel_t ent_rsel;
		logic          ent_wr;
		rha_ent_wsel_t ent_wsel;
		rha_ent_wdat_t ent_wdat;
		logic          cnt_rd;
		rha_cnt_rsel_t cnt_rsel;
		logic          cnt_wr;
		rha_cnt_wsel_t cnt_wsel;
		rha_cnt_wdat_t cnt_wdat;
		rha_l2_ld_t    l2_ld;
		rha_leaf_ld_t  leaf_ld;
		logic          l2cnt_ld;
		logic          l2cnt_clr;
		logic          search_start;
		rha_pool_op_t  pool_op;
		logic          used_inc;
		logic          used_dec;
		logic          out_load;
		rha_status_t   out_status;
	} rha_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic req_free;
		logic used_full;
		logic top_empty;
		logic ent_empty;
		logic slot_empty;
		logic search_done;
		logic search_found;
		logic leaf_last;
		logic l2_last;
		logic out_free;
	} rha_stat_t;

endpackage

// File: rtl/core/rha_pool.sv
// Frame pool: free map flops and a scanner for the lowest free frame.
// Depends on rha_pkg.
`timescale 1ns / 1ps

module rha_pool
	import rha_pkg::*;
#(
	parameter int FRAMES = DEF_FRAMES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rha_pool_op_t                pool_op,
	input  logic [$clog2(FRAMES)-1:0]   give_frame,
	input  logic                        search_start,
	output logic                        search_done,
	output logic                        search_found,
	output logic [$clog2(FRAMES)-1:0]   found_frame
);

	localparam int FW  = $clog2(FRAMES);
	localparam int NCH = (FRAMES + SCAN_CHUNK - 1) / SCAN_CHUNK;
	localparam int CIW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PAD = NCH * SCAN_CHUNK;

	logic [FRAMES-1:0]     free_q;
	logic                  busy_q;
	logic [CIW-1:0]        idx_q;
	logic [PAD-1:0]        padded;
	logic [SCAN_CHUNK-1:0] chunk;
	logic [4:0]            pos;
	logic                  any;
	logic                  last;

	assign padded = PAD'(free_q);
	assign chunk  = padded[{idx_q, 5'd0} +: SCAN_CHUNK];
	assign any    = |chunk;
	assign last   = (idx_q == CIW'(NCH - 1));

	always_comb begin
		pos = '0;
		for (int b = SCAN_CHUNK - 1; b >= 0; b--) begin
			if (chunk[b]) begin
				pos = 5'(b);
			end
		end
	end

	assign found_frame  = FW'({idx_q, pos});
	assign search_done  = busy_q && (any || last);
	assign search_found = any;

	// one chunk of the map per cycle, lowest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (search_start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (any || last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CIW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			case (pool_op)
				POOL_TAKE:                      free_q[found_frame] <= 1'b0;
				POOL_GIVE_L2, POOL_GIVE_LEAF:   free_q[give_frame]  <= 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_take_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		pool_op == POOL_TAKE |-> search_done && search_found)
		else $error("frame taken without a scan hit");
	a_give_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(pool_op == POOL_GIVE_L2 || pool_op == POOL_GIVE_LEAF) |-> !free_q[give_frame])
		else $error("frame given back while already free");
`endif

endmodule

// File: rtl/core/rha_datapath.sv
// Datapath: radix table memories, use counts, counters and the output register.
// Depends on rha_pkg and rha_pool.
`timescale 1ns / 1ps

module rha_datapath
	import rha_pkg::*;
#(
	parameter int FRAMES = DEF_FRAMES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  rha_req_t  req,
	input  logic      rsp_stall,
	output logic      rsp_valid,
	output rha_rsp_t  rsp,
	input  rha_cmd_t  cmd,
	output rha_stat_t st
);

	localparam int FW    = $clog2(FRAMES);
	localparam int CW    = $clog2(FRAMES + 1);
	localparam int DEPTH = FRAMES * ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [CW-1:0] EMPTY = CW'(FRAMES);

	logic [CW-1:0]       top_mem [ENTRIES];
	logic [CW-1:0]       ent_mem [DEPTH];
	logic [CNT_BITS-1:0] cnt_mem [FRAMES];

	logic [CW-1:0]          top_rdata_q, ent_rdata_q;
	logic [CNT_BITS-1:0]    cnt_rdata_q, l2cnt_q;
	logic [HANDLE_BITS-1:0] hin_q, h_q, next_q;
	logic                   req_q;
	logic [USED_BITS-1:0]   used_q;
	logic [FW-1:0]          l2_q, leaf_q;
	logic [AW-1:0]          clr_q;
	logic                   out_valid_q;
	rha_rsp_t               out_q;

	logic [IDX_BITS-1:0] i1, i2, i3;
	logic [FW-1:0]       top_l2, ent_leaf, found_frame, give_frame, cnt_raddr, cnt_waddr;
	logic [AW-1:0]       ent_raddr, ent_waddr;
	logic [CW-1:0]       ent_wdata, top_wdata;
	logic [IDX_BITS-1:0] top_waddr;
	logic                top_we, ent_we;
	logic [CNT_BITS-1:0] cnt_wdata;
	logic                search_done, search_found;

	assign i1       = h_q[23:16];
	assign i2       = h_q[15:8];
	assign i3       = h_q[7:0];
	assign top_l2   = top_rdata_q[FW-1:0];
	assign ent_leaf = ent_rdata_q[FW-1:0];

	rha_pool #(.FRAMES(FRAMES)) u_pool (
		.clk          (clk),
		.arst_n       (arst_n),
		.pool_op      (cmd.pool_op),
		.give_frame   (give_frame),
		.search_start (cmd.search_start),
		.search_done  (search_done),
		.search_found (search_found),
		.found_frame  (found_frame)
	);

	assign give_frame = (cmd.pool_op == POOL_GIVE_LEAF) ? leaf_q : l2_q;

	// top table
	assign top_we    = (cmd.clear && clr_q[AW-1:IDX_BITS] == '0) || cmd.top_wr;
	assign top_waddr = cmd.clear ? clr_q[IDX_BITS-1:0] : i1;
	assign top_wdata = (cmd.clear || cmd.top_wr_empty) ? EMPTY : CW'(found_frame);

	always_ff @(posedge clk) begin
		if (top_we) begin
			top_mem[top_waddr] <= top_wdata;
		end
		if (cmd.top_rd) begin
			top_rdata_q <= top_mem[i1];
		end
	end

	// frame entries
	assign ent_raddr = (cmd.ent_rsel == ERD_L2_TOP) ? {top_l2, i2} : {ent_leaf, i3};
	assign ent_we    = cmd.clear || cmd.ent_wr;

	always_comb begin
		if (cmd.clear) begin
			ent_waddr = clr_q;
		end else if (cmd.ent_wsel == EWR_L2_SLOT) begin
			ent_waddr = {l2_q, i2};
		end else begin
			ent_waddr = {leaf_q, i3};
		end
		if (cmd.clear) begin
			ent_wdata = EMPTY;
		end else begin
			case (cmd.ent_wdat)
				EWD_FOUND: ent_wdata = CW'(found_frame);
				EWD_USED:  ent_wdata = '0;
				default:   ent_wdata = EMPTY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (cmd.ent_rd) begin
			ent_rdata_q <= ent_mem[ent_raddr];
		end
	end

	// use counts
	assign cnt_raddr = (cmd.cnt_rsel == CRD_TOP) ? top_l2 : ent_leaf;

	always_comb begin
		case (cmd.cnt_wsel)
			CWR_FOUND: cnt_waddr = found_frame;
			CWR_L2:    cnt_waddr = l2_q;
			default:   cnt_waddr = leaf_q;
		endcase
		case (cmd.cnt_wdat)
			CWD_ONE:      cnt_wdata = CNT_BITS'(1);
			CWD_L2_INC:   cnt_wdata = l2cnt_q + CNT_BITS'(1);
			CWD_LEAF_INC: cnt_wdata = cnt_rdata_q + CNT_BITS'(1);
			CWD_LEAF_DEC: cnt_wdata = (cnt_rdata_q == '0) ? '0 : cnt_rdata_q - CNT_BITS'(1);
			default:      cnt_wdata = (l2cnt_q == '0) ? '0 : l2cnt_q - CNT_BITS'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_wr) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cmd.cnt_rd) begin
			cnt_rdata_q <= cnt_mem[cnt_raddr];
		end
	end

	// request, frame and count holding registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hin_q <= req.handle_in;
			req_q <= req.req_type;
			h_q   <= req.handle_in;
		end else if (cmd.load_alloc) begin
			h_q <= next_q;
		end
		case (cmd.l2_ld)
			L2_FROM_TOP:   l2_q <= top_l2;
			L2_FROM_FOUND: l2_q <= found_frame;
			default: ;
		endcase
		case (cmd.leaf_ld)
			LF_FROM_ENT:   leaf_q <= ent_leaf;
			LF_FROM_FOUND: leaf_q <= found_frame;
			default: ;
		endcase
		if (cmd.l2cnt_clr) begin
			l2cnt_q <= '0;
		end else if (cmd.l2cnt_ld) begin
			l2cnt_q <= cnt_rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			used_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.load_alloc) begin
				next_q <= next_q + HANDLE_BITS'(1);
			end
			if (cmd.used_inc) begin
				used_q <= used_q + USED_BITS'(1);
			end else if (cmd.used_dec && used_q != '0) begin
				used_q <= used_q - USED_BITS'(1);
			end
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status     <= cmd.out_status;
			out_q.handle_out <= (cmd.out_status == ST_OK && req_q == REQ_ALLOC) ? h_q : hin_q;
			out_q.used_total <= used_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign st.clear_last   = (clr_q == AW'(DEPTH - 1));
	assign st.req_free     = (req_q == REQ_FREE);
	assign st.used_full    = (used_q == FULL_COUNT);
	assign st.top_empty    = (top_rdata_q >= EMPTY);
	assign st.ent_empty    = (ent_rdata_q >= EMPTY);
	assign st.slot_empty   = (ent_rdata_q == EMPTY);
	assign st.search_done  = search_done;
	assign st.search_found = search_found;
	assign st.leaf_last    = (cnt_rdata_q <= CNT_BITS'(1));
	assign st.l2_last      = (l2cnt_q <= CNT_BITS'(1));
	assign st.out_free     = !out_valid_q || !rsp_stall;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FULL_COUNT)
		else $error("handle count above the handle space");
	a_alloc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_alloc |-> !st.used_full && !st.req_free)
		else $error("counter advanced for a full table or a free request");
`endif

endmodule

// File: rtl/core/rha_ctrl.sv
// Controller: sequences table reads, frame scans and updates for each request.
// Depends on rha_pkg.
`timescale 1ns / 1ps

module rha_ctrl
	import rha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  rha_stat_t st,
	output rha_cmd_t  cmd
);

	rha_state_t  state_q, state_d;
	rha_status_t status_q, status_d;
	logic        new_l2_q, new_l2_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			status_q <= ST_OK;
			new_l2_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			new_l2_q <= new_l2_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		new_l2_d       = new_l2_q;
		cmd            = '0;
		cmd.out_status = status_q;
		req_stall      = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.req_free) begin
					cmd.top_rd = 1'b1;
					state_d    = S_F_TOP;
				end else if (st.used_full) begin
					status_d = ST_FULL;
					state_d  = S_OUT;
				end else begin
					cmd.load_alloc = 1'b1;
					state_d        = S_A_RDTOP;
				end
			end
			S_A_RDTOP: begin
				cmd.top_rd = 1'b1;
				state_d    = S_A_TOP;
			end
			S_A_TOP: begin
				new_l2_d = 1'b0;
				if (st.top_empty) begin
					cmd.search_start = 1'b1;
					state_d          = S_A_FIND_L2;
				end else begin
					cmd.l2_ld    = L2_FROM_TOP;
					cmd.ent_rd   = 1'b1;
					cmd.ent_rsel = ERD_L2_TOP;
					cmd.cnt_rd   = 1'b1;
					cmd.cnt_rsel = CRD_TOP;
					state_d      = S_A_L2E;
				end
			end
			S_A_FIND_L2: begin
				if (st.search_done) begin
					if (!st.search_found) begin
						status_d = ST_NOMEM;
						state_d  = S_OUT;
					end else begin
						// fresh level-2 frame: its entries are all empty
						cmd.pool_op      = POOL_TAKE;
						cmd.top_wr       = 1'b1;
						cmd.l2_ld        = L2_FROM_FOUND;
						cmd.l2cnt_clr    = 1'b1;
						cmd.search_start = 1'b1;
						new_l2_d         = 1'b1;
						state_d          = S_A_FIND_LF;
					end
				end
			end
			S_A_L2E: begin
				cmd.l2cnt_ld = 1'b1;
				if (st.ent_empty) begin
					cmd.search_start = 1'b1;
					state_d          = S_A_FIND_LF;
				end else begin
					cmd.leaf_ld  = LF_FROM_ENT;
					cmd.ent_rd   = 1'b1;
					cmd.ent_rsel = ERD_LEAF_ENT;
					cmd.cnt_rd   = 1'b1;
					cmd.cnt_rsel = CRD_ENT;
					state_d      = S_A_LFE;
				end
			end
			S_A_FIND_LF: begin
				if (st.search_done) begin
					if (!st.search_found) begin
						// drop a level-2 frame taken for this handle
						if (new_l2_q) begin
							cmd.top_wr       = 1'b1;
							cmd.top_wr_empty = 1'b1;
							cmd.pool_op      = POOL_GIVE_L2;
						end
						status_d = ST_NOMEM;
						state_d  = S_OUT;
					end else begin
						cmd.pool_op  = POOL_TAKE;
						cmd.ent_wr   = 1'b1;
						cmd.ent_wsel = EWR_L2_SLOT;
						cmd.ent_wdat = EWD_FOUND;
						cmd.cnt_wr   = 1'b1;
						cmd.cnt_wsel = CWR_FOUND;
						cmd.cnt_wdat = CWD_ONE;
						cmd.leaf_ld  = LF_FROM_FOUND;
						state_d      = S_A_NEWLEAF;
					end
				end
			end
			S_A_NEWLEAF: begin
				cmd.cnt_wr   = 1'b1;
				cmd.cnt_wsel = CWR_L2;
				cmd.cnt_wdat = CWD_L2_INC;
				cmd.ent_wr   = 1'b1;
				cmd.ent_wsel = EWR_LEAF_SLOT;
				cmd.ent_wdat = EWD_USED;
				cmd.used_inc = 1'b1;
				status_d     = ST_OK;
				state_d      = S_OUT;
			end
			S_A_LFE: begin
				if (!st.slot_empty) begin
					// slot taken: advance to the next handle
					state_d = S_DECODE;
				end else begin
					cmd.ent_wr   = 1'b1;
					cmd.ent_wsel = EWR_LEAF_SLOT;
					cmd.ent_wdat = EWD_USED;
					cmd.cnt_wr   = 1'b1;
					cmd.cnt_wsel = CWR_LEAF;
					cmd.cnt_wdat = CWD_LEAF_INC;
					cmd.used_inc = 1'b1;
					status_d     = ST_OK;
					state_d      = S_OUT;
				end
			end
			S_F_TOP: begin
				if (st.top_empty) begin
					status_d = ST_NOTALLOC;
					state_d  = S_OUT;
				end else begin
					cmd.l2_ld    = L2_FROM_TOP;
					cmd.ent_rd   = 1'b1;
					cmd.ent_rsel = ERD_L2_TOP;
					cmd.cnt_rd   = 1'b1;
					cmd.cnt_rsel = CRD_TOP;
					state_d      = S_F_L2E;
				end
			end
			S_F_L2E: begin
				cmd.l2cnt_ld = 1'b1;
				if (st.ent_empty) begin
					status_d = ST_NOTALLOC;
					state_d  = S_OUT;
				end else begin
					cmd.leaf_ld  = LF_FROM_ENT;
					cmd.ent_rd   = 1'b1;
					cmd.ent_rsel = ERD_LEAF_ENT;
					cmd.cnt_rd   = 1'b1;
					cmd.cnt_rsel = CRD_ENT;
					state_d      = S_F_LFE;
				end
			end
			S_F_LFE: begin
				if (st.slot_empty) begin
					status_d = ST_NOTALLOC;
					state_d  = S_OUT;
				end else begin
					cmd.ent_wr   = 1'b1;
					cmd.ent_wsel = EWR_LEAF_SLOT;
					cmd.ent_wdat = EWD_EMPTY;
					cmd.cnt_wr   = 1'b1;
					cmd.cnt_wsel = CWR_LEAF;
					cmd.cnt_wdat = CWD_LEAF_DEC;
					cmd.used_dec = 1'b1;
					status_d     = ST_OK;
					if (st.leaf_last) begin
						cmd.pool_op = POOL_GIVE_LEAF;
						state_d     = S_F_GIVE;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_F_GIVE: begin
				cmd.ent_wr   = 1'b1;
				cmd.ent_wsel = EWR_L2_SLOT;
				cmd.ent_wdat = EWD_EMPTY;
				cmd.cnt_wr   = 1'b1;
				cmd.cnt_wsel = CWR_L2;
				cmd.cnt_wdat = CWD_L2_DEC;
				if (st.l2_last) begin
					cmd.pool_op      = POOL_GIVE_L2;
					cmd.top_wr       = 1'b1;
					cmd.top_wr_empty = 1'b1;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_newleaf_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_NEWLEAF |-> $past(state_q) == S_A_FIND_LF)
		else $error("leaf frame installed without a scan");
	a_full_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECODE && !st.req_free && st.used_full) |=> status_q == ST_FULL)
		else $error("full table not reported");
`endif

endmodule

// File: rtl/core/radix_handle_allocator.sv
// Radix handle allocator: an allocate runs at most two frame scans and skips over
//   used slots. One request in flight at a time.
// The next request is taken while a result beat still waits on rsp_stall.
// Reset: asynchronous, arst_n low; after release the table is swept once, with req_stall
// held high, before the first request is taken.
`timescale 1ns / 1ps

module radix_handle_allocator
	import rha_pkg::*;
#(
	parameter int FRAMES = DEF_FRAMES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rha_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rha_rsp_t rsp
);

	// The controller only sequences; every table, count and counter sits in the
	// datapath. They talk through one command struct and one status struct.
	rha_cmd_t  cmd;
	rha_stat_t st;

	rha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath holds the top table (256 entries), the frame entry memory
	// (FRAMES x 256), per-frame use counts, the free map and its scanner,
	// and the output register that carries the result beat.
	rha_datapath #(.FRAMES(FRAMES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench of the radix handle allocator: random and directed request beats,
// checked against a behavioural table model kept here. Depends on rha_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;
	import rha_pkg::*;

	localparam int NFRAMES = DEF_FRAMES;
	localparam int EMPTY   = NFRAMES;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	rha_req_t req;
	logic     rsp_valid;
	logic     rsp_stall;
	rha_rsp_t rsp;

	radix_handle_allocator #(.FRAMES(NFRAMES)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Shadow of the allocator state.
	logic [23:0] m_next;
	int          m_top [256];
	int          m_ent [NFRAMES*256];
	int          m_cnt [NFRAMES];
	bit          m_free [NFRAMES];
	logic [24:0] m_used;

	rha_req_t pending_reqs [$];
	rha_rsp_t expected_rsps [$];
	logic [23:0] live_handles [$];
	int errors;
	int n_alloc, n_free, n_nomem, n_notalloc;
	bit hold_sender;

	function automatic int take_frame();
		for (int i = 0; i < NFRAMES; i++) begin
			if (m_free[i]) begin
				m_free[i] = 0;
				m_cnt[i]  = 0;
				return i;
			end
		end
		return EMPTY;
	endfunction

	function automatic void give_frame(int f);
		m_free[f] = 1;
		m_cnt[f]  = 0;
	endfunction

	function automatic rha_status_t model_alloc(ref logic [23:0] granted);
		int l2, leaf, i1, i2, i3;
		logic [23:0] h;
		if (m_used >= FULL_COUNT)
			return ST_FULL;
		forever begin
			h  = m_next;
			i1 = h[23:16];
			i2 = h[15:8];
			i3 = h[7:0];
			m_next = m_next + 24'd1;
			l2 = m_top[i1];
			if (l2 >= NFRAMES) begin
				l2 = take_frame();
				if (l2 >= NFRAMES)
					return ST_NOMEM;
				m_top[i1] = l2;
			end
			leaf = m_ent[l2*256 + i2];
			if (leaf >= NFRAMES) begin
				leaf = take_frame();
				if (leaf >= NFRAMES) begin
					if (m_cnt[l2] == 0) begin
						m_top[i1] = EMPTY;
						give_frame(l2);
					end
					return ST_NOMEM;
				end
				m_ent[l2*256 + i2] = leaf;
				m_cnt[l2]++;
			end
			if (m_ent[leaf*256 + i3] != EMPTY)
				continue;
			m_ent[leaf*256 + i3] = 0;
			m_cnt[leaf]++;
			m_used++;
			granted = h;
			return ST_OK;
		end
	endfunction

	function automatic rha_status_t model_free(logic [23:0] h);
		int l2, leaf, s2, s3;
		l2 = m_top[h[23:16]];
		if (l2 >= NFRAMES)
			return ST_NOTALLOC;
		s2   = l2*256 + h[15:8];
		leaf = m_ent[s2];
		if (leaf >= NFRAMES)
			return ST_NOTALLOC;
		s3 = leaf*256 + h[7:0];
		if (m_ent[s3] == EMPTY)
			return ST_NOTALLOC;
		m_ent[s3] = EMPTY;
		if (m_used > 0) m_used--;
		if (m_cnt[leaf] > 0) m_cnt[leaf]--;
		if (m_cnt[leaf] == 0) begin
			give_frame(leaf);
			m_ent[s2] = EMPTY;
			if (m_cnt[l2] > 0) m_cnt[l2]--;
			if (m_cnt[l2] == 0) begin
				give_frame(l2);
				m_top[h[23:16]] = EMPTY;
			end
		end
		return ST_OK;
	endfunction

	// Work out the response of one accepted request and queue it.
	function automatic void predict_rsp(rha_req_t r);
		rha_rsp_t e;
		logic [23:0] hout;
		hout = r.handle_in;
		if (r.req_type == REQ_ALLOC) begin
			e.status = model_alloc(hout);
			if (e.status == ST_OK) begin
				live_handles.push_back(hout);
				n_alloc++;
			end else if (e.status == ST_NOMEM)
				n_nomem++;
		end else begin
			e.status = model_free(r.handle_in);
			if (e.status == ST_OK) begin
				n_free++;
				foreach (live_handles[i])
					if (live_handles[i] == r.handle_in) begin
						live_handles.delete(i);
						break;
					end
			end else
				n_notalloc++;
		end
		e.handle_out = hout;
		e.used_total = m_used;
		expected_rsps.push_back(e);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Driver: present queued beats, hold them while stalled.
	int drv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			drv_gap   = 0;
		end else begin
			if (req_valid && !req_stall) begin
				predict_rsp(req);
				drv_gap = gap_len();
			end
			if (req_valid && req_stall) begin
				// hold the stalled beat
			end else if (drv_gap > 0) begin
				drv_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0 && !hold_sender) begin
				req_valid <= 1'b1;
				req       <= pending_reqs.pop_front();
			end else
				req_valid <= 1'b0;
		end
	end

	// Monitor: random back-pressure; compare every response beat with the oldest prediction.
	int stall_len;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_len = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("unexpected response beat at t=%0t", $realtime);
					errors++;
				end else begin
					rha_rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status)
						report_mismatch("status", 32'(rsp.status), 32'(e.status));
					if (rsp.handle_out !== e.handle_out)
						report_mismatch("handle_out", 32'(rsp.handle_out),
							32'(e.handle_out));
					if (rsp.used_total !== e.used_total)
						report_mismatch("used_total", 32'(rsp.used_total),
							32'(e.used_total));
				end
			end
			if (stall_len > 0) begin
				stall_len--;
				rsp_stall <= 1'b1;
			end else begin
				stall_len = gap_len();
				rsp_stall <= (stall_len > 0);
			end
		end
	end

	function automatic rha_req_t mk(logic t, logic [23:0] h);
		rha_req_t r;
		r.req_type  = t;
		r.handle_in = h;
		return r;
	endfunction

	// Wait until the pending queue is drained and every response has come back.
	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int p;
		logic [23:0] h;
		errors = 0;
		hold_sender = 0;
		m_next = '0;
		m_used = '0;
		foreach (m_top[i]) m_top[i] = EMPTY;
		foreach (m_ent[i]) m_ent[i] = EMPTY;
		for (int i = 0; i < NFRAMES; i++) begin
			m_cnt[i]  = 0;
			m_free[i] = 1;
		end
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: free into empty tables, a few allocates, free used and unused slots,
		// double free, extreme handle values, then a freed leaf taken again.
		pending_reqs.push_back(mk(REQ_FREE, 24'h000000));
		pending_reqs.push_back(mk(REQ_FREE, 24'hffffff));
		for (int i = 0; i < 4; i++)
			pending_reqs.push_back(mk(REQ_ALLOC, 24'hffffff));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000001));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000001));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000005));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000100));
		pending_reqs.push_back(mk(REQ_FREE, 24'h010000));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000000));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000002));
		pending_reqs.push_back(mk(REQ_FREE, 24'h000003));
		pending_reqs.push_back(mk(REQ_ALLOC, 24'h5a5a5a));
		pending_reqs.push_back(mk(REQ_ALLOC, 24'ha5a5a5));
		// wait out every response before going on
		drain();
		hold_sender = 1;
		@(posedge clk);
		hold_sender = 0;

		// Random: mostly allocates and frees of live handles, some noise frees.
		for (int n = 0; n < 880; n++) begin
			p = $urandom_range(99);
			if (n % 100 == 50) begin
				// at n % 100 == 50, drain the queue and all outstanding responses
				drain();
			end
			if (p < 55)
				pending_reqs.push_back(mk(REQ_ALLOC, 24'($urandom())));
			else if (p < 85 && live_handles.size() + pending_reqs.size() > 0) begin
				drain();
				if (live_handles.size() > 0) begin
					h = live_handles[$urandom_range(live_handles.size() - 1)];
					pending_reqs.push_back(mk(REQ_FREE, h));
				end else
					pending_reqs.push_back(mk(REQ_FREE, 24'($urandom())));
			end else begin
				h = 24'($urandom());
				if (p & 1) h[23:8] = m_next[23:8];
				pending_reqs.push_back(mk(REQ_FREE, h));
			end
			while (pending_reqs.size() > 8) @(posedge clk);
		end
		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d grants, %0d frees, %0d out-of-frame answers, %0d bad frees",
			n_alloc, n_free, n_nomem, n_notalloc);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

endmodule
